// ===== rtl/core/pse_pkg.sv =====
// ============================================================================
// pse_pkg
// Types and codes shared by the postfix stack evaluator and its divider.
// ============================================================================
`default_nettype none

package pse_pkg;

   typedef enum logic [1:0] {
      KIND_NUMBER = 2'd0,
      KIND_OPER   = 2'd1,
      KIND_END    = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } oper_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FEW       = 3'd1,
      ST_TRAILING  = 3'd2,
      ST_DIV_ZERO  = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_MUL,
      S_WRITE,
      S_RESULT
   } state_type;

   localparam int unsigned DATA_W = 64;

   // divider handshake
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/pse_divider.sv =====
// ============================================================================
// pse_divider
// Signed 64-bit truncating divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module pse_divider (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pse_pkg::div_ctl_type    ctl,
   input  wire logic [63:0]             dividend,
   input  wire logic [63:0]             divisor,
   output pse_pkg::div_sts_type         sts,
   output logic [63:0]                  quotient
);
   import pse_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  count_ff, count_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [64:0] trial;
   logic [63:0] mag_a;
   logic [63:0] mag_b;

   assign mag_a = dividend[63] ? 64'd0 - dividend : dividend;
   assign mag_b = divisor[63] ? 64'd0 - divisor : divisor;
   assign trial = {rem_ff, quo_ff[63]} - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         count_in = 7'd0;
         rem_in   = 64'd0;
         quo_in   = mag_a;
         den_in   = mag_b;
         neg_in   = dividend[63] ^ divisor[63];
      end else if (busy_ff) begin
         // restoring step: shift a dividend bit in, subtract when it fits
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         count_in = count_ff + 7'd1;
         if (count_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 7'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign quotient  = neg_ff ? 64'd0 - quo_ff : quo_ff;
   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff) else $error("divider did not start");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff < 7'd64) else $error("divider count overrun");

endmodule

`default_nettype wire

// ===== rtl/core/postfix_stack_evaluator.sv =====
// ============================================================================
// postfix_stack_evaluator
// Reverse Polish evaluator on a 64-bit operand stack held in memory.
// ============================================================================
// Flow: a number beat passes S_READ only; add/subtract go on through S_EXEC
// and S_WRITE, multiply also S_MUL, divide also S_DIV (64-step divider); an end
// beat waits in S_RESULT while the output register holds an unaccepted result.
// One beat is in work at a time; req_tready is low while it runs.
// The operand stack is read and written through one memory port pair.
// Reset (synchronous, active high) empties the stack and clears any error;
// stack contents are not cleared.
`default_nettype none

module postfix_stack_evaluator #(
   parameter int unsigned STACK_DEPTH    = 64,
   parameter int unsigned POSITION_WIDTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // kind[1:0], number_value[65:2], operator_code[67:66], token_position[83:68]
   input  wire logic [87:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_value[63:0], status[66:64], error_position[82:67],
   // error_position_valid[83]
   output logic [87:0]       rsp_tdata
);
   import pse_pkg::*;

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned PW = (POSITION_WIDTH < 16) ? POSITION_WIDTH : 16;

   // stack memory: value, position, position-known flag per entry
   logic [63:0]             mem_val [STACK_DEPTH];
   logic [PW-1:0]           mem_pos [STACK_DEPTH];
   logic                    mem_kn  [STACK_DEPTH];

   state_type               state_ff, state_in;
   logic [DW-1:0]           depth_ff, depth_in;
   logic                    err_ff, err_in;
   status_type              ecode_ff, ecode_in;
   logic [15:0]             epos_ff, epos_in;
   logic                    ekn_ff, ekn_in;

   // latched token
   kind_type                kind_ff, kind_in;
   logic [63:0]             num_ff, num_in;
   oper_type                op_ff, op_in;
   logic [PW-1:0]           tpos_ff, tpos_in;

   // memory ports
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [63:0]             wr_val;
   logic [PW-1:0]           wr_pos;
   logic                    wr_kn;
   logic [AW-1:0]           rd_addr_a, rd_addr_b;
   logic [63:0]             rd_a_ff, rd_b_ff;
   logic [PW-1:0]           rd_pos_b_ff;
   logic                    rd_kn_b_ff;

   // operation result register
   logic [63:0]             res_ff, res_in;
   logic [1:0]              mcnt_ff, mcnt_in;
   logic [63:0]             mac_ff, mac_in;

   // output register
   logic                    ov_ff, ov_in;
   logic [87:0]             od_ff, od_in;

   div_ctl_type             dctl;
   div_sts_type             dsts;
   logic [63:0]             dquo;

   logic [31:0]             pa, pb;
   logic [63:0]             pprod;

   pse_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .dividend (rd_a_ff),
      .divisor  (rd_b_ff),
      .sts      (dsts),
      .quotient (dquo)
   );

   // lhs at depth-2 on port A, rhs at depth-1 on port B; end token reads bottom on B
   always_comb begin
      rd_addr_a = AW'(depth_ff - DW'(2));
      rd_addr_b = (kind_ff == KIND_END) ? AW'(0) : AW'(depth_ff - DW'(1));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_val[wr_addr] <= wr_val;
         mem_pos[wr_addr] <= wr_pos;
         mem_kn[wr_addr]  <= wr_kn;
      end
      rd_a_ff     <= mem_val[rd_addr_a];
      rd_b_ff     <= mem_val[rd_addr_b];
      rd_pos_b_ff <= mem_pos[rd_addr_b];
      rd_kn_b_ff  <= mem_kn[rd_addr_b];
   end

   // 64x64 low product in three 32x32 partial products, one per cycle
   always_comb begin
      case (mcnt_ff)
         2'd0:    begin pa = rd_a_ff[31:0];  pb = rd_b_ff[31:0];  end
         2'd1:    begin pa = rd_a_ff[63:32]; pb = rd_b_ff[31:0];  end
         2'd2:    begin pa = rd_a_ff[31:0];  pb = rd_b_ff[63:32]; end
         default: begin pa = 32'd0;          pb = 32'd0;          end
      endcase
      pprod = {32'd0, pa} * {32'd0, pb};
   end

   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      err_in    = err_ff;
      ecode_in  = ecode_ff;
      epos_in   = epos_ff;
      ekn_in    = ekn_ff;
      kind_in   = kind_ff;
      num_in    = num_ff;
      op_in     = op_ff;
      tpos_in   = tpos_ff;
      res_in    = res_ff;
      mcnt_in   = mcnt_ff;
      mac_in    = mac_ff;
      ov_in     = ov_ff;
      od_in     = od_ff;
      wr_en     = 1'b0;
      wr_addr   = AW'(depth_ff);
      wr_val    = num_ff;
      wr_pos    = tpos_ff;
      wr_kn     = 1'b1;
      dctl.start = 1'b0;
      req_tready = 1'b0;

      if (ov_ff && rsp_tready) ov_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = kind_type'(req_tdata[1:0]);
               num_in   = req_tdata[65:2];
               op_in    = oper_type'(req_tdata[67:66]);
               tpos_in  = req_tdata[68 +: PW];
               state_in = S_READ;
            end
         end
         S_READ: begin
            // memory read of the addressed entries is registered here for use in S_EXEC
            state_in = S_EXEC;
            if (kind_ff == KIND_NUMBER) begin
               state_in = S_IDLE;
               if (!err_ff) begin
                  if (depth_ff >= DW'(STACK_DEPTH)) begin
                     err_in = 1'b1; ecode_in = ST_OVERFLOW;
                     epos_in = 16'(tpos_ff); ekn_in = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     depth_in = depth_ff + DW'(1);
                  end
               end
            end else if (kind_ff == KIND_SPARE) begin
               state_in = S_IDLE;
            end else if (kind_ff == KIND_OPER && err_ff) begin
               state_in = S_IDLE;
            end else if (kind_ff == KIND_OPER && depth_ff < DW'(2)) begin
               err_in = 1'b1; ecode_in = ST_FEW;
               epos_in = 16'(tpos_ff); ekn_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EXEC: begin
            if (kind_ff == KIND_END) begin
               state_in = S_RESULT;
            end else begin
               case (op_ff)
                  OP_ADD: begin res_in = rd_a_ff + rd_b_ff; state_in = S_WRITE; end
                  OP_SUB: begin res_in = rd_a_ff - rd_b_ff; state_in = S_WRITE; end
                  OP_MUL: begin mcnt_in = 2'd0; mac_in = 64'd0; state_in = S_MUL; end
                  OP_DIV: begin
                     if (rd_b_ff == 64'd0) begin
                        err_in = 1'b1; ecode_in = ST_DIV_ZERO;
                        epos_in = 16'(tpos_ff); ekn_in = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        dctl.start = 1'b1;
                        state_in = S_DIV;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MUL: begin
            if (mcnt_ff == 2'd0) mac_in = pprod;
            else mac_in = mac_ff + {pprod[31:0], 32'd0};
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd2) begin
               res_in = mac_ff + {pprod[31:0], 32'd0};
               state_in = S_WRITE;
            end
         end
         S_DIV: begin
            if (dsts.done) begin
               res_in = dquo;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(depth_ff - DW'(2));
            wr_val   = res_ff;
            wr_pos   = '0;
            wr_kn    = 1'b0;
            depth_in = depth_ff - DW'(1);
            state_in = S_IDLE;
         end
         S_RESULT: begin
            // output register must be free before the result is loaded
            if (!ov_in) begin
               od_in = '0;
               if (err_ff) begin
                  od_in[66:64] = ecode_ff;
                  od_in[82:67] = ekn_ff ? epos_ff : 16'd0;
                  od_in[83]    = ekn_ff;
               end else if (depth_ff != DW'(1)) begin
                  od_in[66:64] = ST_TRAILING;
                  if (depth_ff != DW'(0) && rd_kn_b_ff) begin
                     od_in[82:67] = 16'(rd_pos_b_ff);
                     od_in[83]    = 1'b1;
                  end
               end else begin
                  od_in[66:64] = ST_OK;
                  od_in[63:0]  = rd_b_ff;
               end
               ov_in    = 1'b1;
               depth_in = '0;
               err_in   = 1'b0;
               ecode_in = ST_OK;
               epos_in  = 16'd0;
               ekn_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= '0;
         err_ff   <= 1'b0;
         ecode_ff <= ST_OK;
         epos_ff  <= 16'd0;
         ekn_ff   <= 1'b0;
         ov_ff    <= 1'b0;
         mcnt_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         err_ff   <= err_in;
         ecode_ff <= ecode_in;
         epos_ff  <= epos_in;
         ekn_ff   <= ekn_in;
         ov_ff    <= ov_in;
         mcnt_ff  <= mcnt_in;
      end
      kind_ff <= kind_in;
      num_ff  <= num_in;
      op_ff   <= op_in;
      tpos_ff <= tpos_in;
      res_ff  <= res_in;
      mac_ff  <= mac_in;
      od_ff   <= od_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH)) else $error("stack depth beyond capacity");
   a_idle_only_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_result_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && state_in == S_IDLE) |=> depth_ff == '0 && !err_ff)
      else $error("end beat did not clear stack");
   a_write_no_error: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> !err_ff) else $error("stack write after error");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the postfix stack evaluator: directed token beats,
// a stack overflow run, then random well-formed expressions mixed with broken
// ones, all checked against a behavioural stack predictor held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pse_pkg::*;

   localparam int unsigned DEPTH = 64;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;

   postfix_stack_evaluator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] value;
      logic [1:0]  oper;
      logic [15:0] pos;
   } token_type;

   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  status;
      logic [15:0] epos;
      logic        evalid;
   } verdict_type;

   // directed row: token plus an optional typed-in verdict
   typedef struct {
      token_type   tok;
      bit          typed;
      verdict_type want;
   } row_type;

   // predictor state
   logic [63:0] stk_val [DEPTH];
   logic [15:0] stk_pos [DEPTH];
   logic        stk_known [DEPTH];
   int unsigned stk_depth;
   bit          err_seen;
   status_type  err_code;
   logic [15:0] err_pos;
   logic        err_known;

   verdict_type verdicts_due[$];
   int          failures;
   int          beats_sent;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("** postfix_stack_evaluator: FAILED **");
      $finish;
   end

   function automatic logic [63:0] quotient(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q  = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic void flag_error(status_type code, logic [15:0] pos);
      err_seen  = 1'b1;
      err_code  = code;
      err_pos   = pos;
      err_known = 1'b1;
   endfunction

   function automatic void clear_stack();
      stk_depth = 0;
      err_seen  = 1'b0;
      err_code  = ST_OK;
      err_pos   = '0;
      err_known = 1'b0;
   endfunction

   // advance the predictor by one accepted token; queue a verdict on end
   function automatic void evaluate(token_type t);
      logic [63:0] l, r, res;
      verdict_type v;
      case (kind_type'(t.kind))
         KIND_NUMBER: begin
            if (!err_seen) begin
               if (stk_depth >= DEPTH) flag_error(ST_OVERFLOW, t.pos);
               else begin
                  stk_val[stk_depth]   = t.value;
                  stk_pos[stk_depth]   = t.pos;
                  stk_known[stk_depth] = 1'b1;
                  stk_depth++;
               end
            end
         end
         KIND_OPER: begin
            if (!err_seen) begin
               if (stk_depth < 2) flag_error(ST_FEW, t.pos);
               else begin
                  r = stk_val[stk_depth-1];
                  l = stk_val[stk_depth-2];
                  case (oper_type'(t.oper))
                     OP_ADD:  res = l + r;
                     OP_SUB:  res = l - r;
                     OP_MUL:  res = l * r;
                     default: res = (r == 0) ? '0 : quotient(l, r);
                  endcase
                  if (oper_type'(t.oper) == OP_DIV && r == 0) flag_error(ST_DIV_ZERO, t.pos);
                  else begin
                     stk_depth -= 1;
                     stk_val[stk_depth-1]   = res;
                     stk_pos[stk_depth-1]   = '0;
                     stk_known[stk_depth-1] = 1'b0;
                  end
               end
            end
         end
         KIND_END: begin
            v = '0;
            if (err_seen) begin
               v.status = err_code;
               v.evalid = err_known;
               v.epos   = err_known ? err_pos : '0;
            end else if (stk_depth != 1) begin
               v.status = ST_TRAILING;
               if (stk_depth > 0 && stk_known[0]) begin
                  v.evalid = 1'b1;
                  v.epos   = stk_pos[0];
               end
            end else begin
               v.status = ST_OK;
               v.value  = stk_val[0];
            end
            verdicts_due.push_back(v);
            clear_stack();
         end
         default: ;  // spare kind: ignored
      endcase
   endfunction

   function automatic logic [87:0] pack_token(token_type t);
      return {4'b0, t.pos, t.oper, t.value, t.kind};
   endfunction

   // drive one beat, with a random gap first when the burst has ended
   int burst_left;
   task automatic send(token_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= pack_token(t);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      evaluate(t);
      beats_sent++;
   endtask

   function automatic token_type mk(kind_type k, logic [63:0] v, oper_type o,
                                    logic [15:0] p);
      token_type t;
      t.kind = k; t.value = v; t.oper = o; t.pos = p;
      return t;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 64'sh8000_0000_0000_0000;
         1: return '1;
         2: return '0;
         3: return 64'(int'($urandom_range(0, 20)) - 10);
         default: return rand64();
      endcase
   endfunction

   // random expression: mostly well-formed, sometimes broken
   task automatic send_expression();
      int n_nums, pending, target;
      bit broken;
      broken = ($urandom_range(0, 4) == 0);
      target = ($urandom_range(0, 40) == 0) ? DEPTH + 1 : $urandom_range(1, 8);
      pending = 0; n_nums = 0;
      while (n_nums < target || pending > 1) begin
         if (n_nums < target && (pending < 2 || $urandom_range(0, 1))) begin
            send(mk(KIND_NUMBER, rand_operand(), OP_ADD, 16'($urandom)));
            n_nums++; pending++;
         end else begin
            send(mk(KIND_OPER, rand64(), oper_type'($urandom_range(0, 3)),
                    16'($urandom)));
            pending--;
         end
         if (broken && $urandom_range(0, 5) == 0)
            send(mk(kind_type'($urandom_range(0, 3)), rand64(),
                    oper_type'($urandom_range(0, 3)), 16'($urandom)));
      end
      if (broken && $urandom_range(0, 1))
         send(mk(KIND_OPER, rand64(), oper_type'($urandom_range(0, 3)), 16'($urandom)));
      send(mk(KIND_END, rand64(), oper_type'($urandom_range(0, 3)), 16'($urandom)));
   endtask

   // receiver stall pattern: stretches of steady acceptance and of random stalls
   int stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 200;
         rsp_tready  <= (stall_phase < 60) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   // result checking against the oldest due verdict
   always @(posedge clock) begin
      verdict_type got, exp_v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[63:0], rsp_tdata[66:64], rsp_tdata[82:67], rsp_tdata[83]};
         if (verdicts_due.size() == 0) begin
            $error("result beat with nothing due");
            failures++;
         end else begin
            exp_v = verdicts_due.pop_front();
            if (got.value !== exp_v.value) begin
               $error("result_value exp %h got %h", exp_v.value, got.value); failures++;
            end
            if (got.status !== exp_v.status) begin
               $error("status exp %0d got %0d", exp_v.status, got.status); failures++;
            end
            if (got.epos !== exp_v.epos) begin
               $error("error_position exp %h got %h", exp_v.epos, got.epos); failures++;
            end
            if (got.evalid !== exp_v.evalid) begin
               $error("error_position_valid exp %b got %b", exp_v.evalid, got.evalid);
               failures++;
            end
         end
      end
   end

   localparam logic [63:0] MAX_NEG = 64'sh8000_0000_0000_0000;
   localparam logic [63:0] MAX_POS = 64'sh7FFF_FFFF_FFFF_FFFF;

   row_type plan[$];

   function automatic void add_row(token_type t, bit typed = 0, verdict_type w = '0);
      row_type r;
      r.tok = t; r.typed = typed; r.want = w;
      plan.push_back(r);
   endfunction

   initial begin
      int waited;
      failures    = 0;
      beats_sent  = 0;
      burst_left  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      clear_stack();

      // end straight after reset: empty stack, trailing, no position
      add_row(mk(KIND_END, '0, OP_ADD, 16'h0000), 1, {64'd0, 3'(ST_TRAILING), 16'h0, 1'b0});
      // too few operands
      add_row(mk(KIND_NUMBER, MAX_POS, OP_ADD, 16'h0001));
      add_row(mk(KIND_OPER, '0, OP_SUB, 16'hFFFF));
      add_row(mk(KIND_NUMBER, '0, OP_ADD, 16'h0003));
      add_row(mk(KIND_END, '1, OP_DIV, 16'h0004), 1, {64'd0, 3'(ST_FEW), 16'hFFFF, 1'b1});
      // most negative by minus one wraps
      add_row(mk(KIND_NUMBER, MAX_NEG, OP_DIV, 16'h0010));
      add_row(mk(KIND_NUMBER, '1, OP_MUL, 16'h0011));
      add_row(mk(KIND_OPER, '1, OP_DIV, 16'h0012));
      add_row(mk(KIND_END, '0, OP_ADD, 16'h0013), 1, {MAX_NEG, 3'(ST_OK), 16'h0, 1'b0});
      // divide by zero
      add_row(mk(KIND_NUMBER, 64'd7, OP_ADD, 16'hAAAA));
      add_row(mk(KIND_NUMBER, 64'd0, OP_ADD, 16'h5555));
      add_row(mk(KIND_OPER, '0, OP_DIV, 16'h1234));
      add_row(mk(KIND_END, '0, OP_ADD, 16'h0), 1, {64'd0, 3'(ST_DIV_ZERO), 16'h1234, 1'b1});
      // add wraps, then sub and mul; spare kind ignored
      add_row(mk(KIND_NUMBER, MAX_POS, OP_ADD, 16'h0020));
      add_row(mk(KIND_NUMBER, 64'd1, OP_ADD, 16'h0021));
      add_row(mk(KIND_OPER, '0, OP_ADD, 16'h0022));
      add_row(mk(KIND_SPARE, '1, OP_DIV, 16'hFFFF));
      add_row(mk(KIND_NUMBER, MAX_NEG, OP_ADD, 16'h0023));
      add_row(mk(KIND_OPER, '0, OP_SUB, 16'h0024));
      add_row(mk(KIND_NUMBER, -64'sd3, OP_ADD, 16'h0025));
      add_row(mk(KIND_OPER, '0, OP_MUL, 16'h0026));
      add_row(mk(KIND_END, '0, OP_ADD, 16'h0027));
      // trailing operands with known bottom position
      add_row(mk(KIND_NUMBER, 64'd5, OP_ADD, 16'hBEEF));
      add_row(mk(KIND_NUMBER, 64'd6, OP_ADD, 16'h0031));
      add_row(mk(KIND_END, '0, OP_ADD, 16'h0032), 1, {64'd0, 3'(ST_TRAILING), 16'hBEEF, 1'b1});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         send(plan[i].tok);
         // a typed-in verdict must agree with the predictor's own
         if (plan[i].typed && verdicts_due[$] !== plan[i].want) begin
            $error("directed row %0d verdict exp %h got %h", i, plan[i].want,
                   verdicts_due[$]);
            failures++;
         end
      end

      // overflow: fill the stack and push once more
      for (int i = 0; i <= DEPTH; i++)
         send(mk(KIND_NUMBER, rand64(), OP_ADD, 16'(i)));
      send(mk(KIND_END, '0, OP_ADD, 16'h0));

      // random expressions until about 1500 beats in all
      while (beats_sent < 1500)
         send_expression();

      req_tvalid <= 1'b0;
      waited = 0;
      while (verdicts_due.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (verdicts_due.size() == 0 && failures == 0)
         $display("** postfix_stack_evaluator: PASSED **");
      else
         $display("** postfix_stack_evaluator: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
